// ===== hdl/tmq_pkg.sv =====
// Shared constants, codes and types of the timer expiry queue.
`default_nettype none

package tmq_pkg;

    localparam int TIMER_SLOTS  = 16;
    localparam int TIME_BITS    = 48;
    localparam int SLOT_BITS    = $clog2(TIMER_SLOTS);
    localparam int TAG_BITS     = 16;
    localparam int TIMEOUT_BITS = 31;
    localparam int MAX_FIRES    = TIMER_SLOTS;
    localparam int FIRE_BITS    = $clog2(MAX_FIRES + 1);

    // Operation codes of an input item.
    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_EXEC   = 2'd2;

    // Kinds of result.
    localparam logic [1:0] KIND_ADD_ACK    = 2'd0;
    localparam logic [1:0] KIND_REMOVE_ACK = 2'd1;
    localparam logic [1:0] KIND_FIRED      = 2'd2;
    localparam logic [1:0] KIND_WAIT       = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_FULL       = 2'd1;
    localparam logic [1:0] STATUS_NOT_ACTIVE = 2'd2;

    // One timer as held in a cell of the sorted chain.
    typedef struct packed {
        logic                 valid;
        logic [TIME_BITS-1:0] expiry;
        logic [TAG_BITS-1:0]  tag;
        logic [SLOT_BITS-1:0] slot;
    } t_entry;

    localparam t_entry EMPTY_ENTRY = '0;

    // Operation broadcast to every cell.
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_POP    = 2'd3
    } t_op;

    typedef struct packed {
        t_op                  op;
        t_entry               entry;
        logic [SLOT_BITS-1:0] rm_slot;
    } t_cmd;

endpackage

`default_nettype wire

// ===== hdl/timer_expiry_queue.sv =====
// Top level of the timer expiry queue: sequencer, slot map, chain and result register.
`default_nettype none

// The queue holds up to TIMER_SLOTS one-shot timers in a chain of cells that
// is kept sorted by expiration time, with equal expirations in the order they
// were added, so the next timer to fire always sits in the head cell. The block
// takes one item at a time: o_ready is high only while no item is in work. An
// add or a remove first captures the item (the saturating expiration sum is
// registered here); then every cell compares the new expiration (add) or the
// handle (remove) with its own and the chain shifts right or left in a single
// step. An execute fires at most MAX_FIRES timers, sixteen at sixteen slots:
// at each step the head cell is checked against the captured time and either
// popped as a fired result or turned into the final wait report. Every result
// goes through one output register, so the sequencer advances only in cycles
// in which that register is empty or its result is being transferred; a stalled
// output stretches the item by the stall. A lowest-free-slot map in flip-flops
// hands out timer handles and answers whether a handle to be removed is active.

module timer_expiry_queue (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [1:0]                      i_func,
    input  wire logic [tmq_pkg::TIME_BITS-1:0]   i_now_ms,
    input  wire logic [tmq_pkg::TIMEOUT_BITS-1:0] i_timeout_ms,
    input  wire logic [tmq_pkg::TAG_BITS-1:0]    i_owner_tag,
    input  wire logic [tmq_pkg::SLOT_BITS-1:0]   i_handle,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [1:0]                           o_kind,
    output logic [1:0]                           o_status,
    output logic [tmq_pkg::SLOT_BITS-1:0]        o_slot,
    output logic [tmq_pkg::TAG_BITS-1:0]         o_tag_out,
    output logic [tmq_pkg::TIME_BITS-1:0]        o_wait_ms,
    output logic                                 o_last
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ADD    = 4'b0010,
        S_REMOVE = 4'b0100,
        S_EXEC   = 4'b1000
    } t_state;

    localparam int TB = tmq_pkg::TIME_BITS;
    localparam int SB = tmq_pkg::SLOT_BITS;
    localparam int NS = tmq_pkg::TIMER_SLOTS;

    t_state                           r_state, n_state;
    logic [NS-1:0]                    r_busy, n_busy;
    logic [tmq_pkg::FIRE_BITS-1:0]    r_fires, n_fires;
    logic [TB-1:0]                    r_now;
    logic [TB-1:0]                    r_key;
    logic [tmq_pkg::TAG_BITS-1:0]     r_tag;
    logic [SB-1:0]                    r_handle;

    logic                             r_out_valid, n_out_valid;
    logic [1:0]                       r_kind, n_kind;
    logic [1:0]                       r_status, n_status;
    logic [SB-1:0]                    r_slot, n_slot;
    logic [tmq_pkg::TAG_BITS-1:0]     r_tag_out, n_tag_out;
    logic [TB-1:0]                    r_wait, n_wait;
    logic                             r_last, n_last;

    logic                             w_accept;
    logic                             w_out_free;
    logic [TB:0]                      w_sum;
    logic [TB-1:0]                    w_key;
    logic                             w_free_found;
    logic [SB-1:0]                    w_free_slot;
    logic                             w_handle_ok;
    logic                             w_head_due;
    tmq_pkg::t_cmd                    w_cmd;
    tmq_pkg::t_entry                  w_cells [NS];
    logic [NS-1:0]                    w_cell_valid;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    // The result register can take a new result when empty or when its result leaves now.
    assign w_out_free = !r_out_valid || i_ready;

    // Expiration saturates at the largest representable time.
    assign w_sum = {1'b0, i_now_ms} + (TB+1)'(i_timeout_ms);
    assign w_key = w_sum[TB] ? {TB{1'b1}} : w_sum[TB-1:0];

    // Lowest free slot: the last match of a downward scan wins.
    always_comb begin
        w_free_found = 1'b0;
        w_free_slot  = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                w_free_found = 1'b1;
                w_free_slot  = SB'(i);
            end
        end
    end

    assign w_handle_ok = (32'(r_handle) < 32'(NS)) && r_busy[r_handle];
    assign w_head_due  = w_cells[0].valid && (w_cells[0].expiry <= r_now);

    always_comb begin
        for (int i = 0; i < NS; i++) begin
            w_cell_valid[i] = w_cells[i].valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_busy       = r_busy;
        n_fires      = r_fires;
        n_out_valid  = r_out_valid && !i_ready;
        n_kind       = r_kind;
        n_status     = r_status;
        n_slot       = r_slot;
        n_tag_out    = r_tag_out;
        n_wait       = r_wait;
        n_last       = r_last;
        w_cmd.op     = tmq_pkg::OP_HOLD;
        w_cmd.entry.valid  = 1'b1;
        w_cmd.entry.expiry = r_key;
        w_cmd.entry.tag    = r_tag;
        w_cmd.entry.slot   = w_free_slot;
        w_cmd.rm_slot      = r_handle;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_fires = '0;
                    case (i_func)
                        tmq_pkg::FUNC_ADD:    n_state = S_ADD;
                        tmq_pkg::FUNC_REMOVE: n_state = S_REMOVE;
                        tmq_pkg::FUNC_EXEC:   n_state = S_EXEC;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = tmq_pkg::KIND_ADD_ACK;
                    n_tag_out   = '0;
                    n_wait      = '0;
                    n_last      = 1'b1;
                    if (w_free_found) begin
                        w_cmd.op             = tmq_pkg::OP_INSERT;
                        n_busy[w_free_slot]  = 1'b1;
                        n_status             = tmq_pkg::STATUS_OK;
                        n_slot               = w_free_slot;
                    end else begin
                        n_status = tmq_pkg::STATUS_FULL;
                        n_slot   = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            S_REMOVE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = tmq_pkg::KIND_REMOVE_ACK;
                    n_slot      = r_handle;
                    n_tag_out   = '0;
                    n_wait      = '0;
                    n_last      = 1'b1;
                    if (w_handle_ok) begin
                        w_cmd.op         = tmq_pkg::OP_REMOVE;
                        n_busy[r_handle] = 1'b0;
                        n_status         = tmq_pkg::STATUS_OK;
                    end else begin
                        n_status = tmq_pkg::STATUS_NOT_ACTIVE;
                    end
                    n_state = S_IDLE;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = tmq_pkg::STATUS_OK;
                    if (w_head_due && (r_fires != tmq_pkg::FIRE_BITS'(tmq_pkg::MAX_FIRES))) begin
                        // Fire the head timer and let the chain move up by one.
                        w_cmd.op                = tmq_pkg::OP_POP;
                        n_busy[w_cells[0].slot] = 1'b0;
                        n_fires                 = r_fires + 1'b1;
                        n_kind                  = tmq_pkg::KIND_FIRED;
                        n_slot                  = w_cells[0].slot;
                        n_tag_out               = w_cells[0].tag;
                        n_wait                  = '0;
                        n_last                  = 1'b0;
                    end else begin
                        // Wait report: zero when the chain is empty or due timers remain.
                        n_kind    = tmq_pkg::KIND_WAIT;
                        n_slot    = '0;
                        n_tag_out = '0;
                        n_wait    = (w_cells[0].valid && !w_head_due) ?
                                    (w_cells[0].expiry - r_now) : '0;
                        n_last    = 1'b1;
                        n_state   = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    tmq_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_cells (w_cells)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= '0;
            r_fires     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_fires     <= n_fires;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now    <= i_now_ms;
            r_key    <= w_key;
            r_tag    <= i_owner_tag;
            r_handle <= i_handle;
        end
        r_kind    <= n_kind;
        r_status  <= n_status;
        r_slot    <= n_slot;
        r_tag_out <= n_tag_out;
        r_wait    <= n_wait;
        r_last    <= n_last;
    end

    assign o_valid   = r_out_valid;
    assign o_kind    = r_kind;
    assign o_status  = r_status;
    assign o_slot    = r_slot;
    assign o_tag_out = r_tag_out;
    assign o_wait_ms = r_wait;
    assign o_last    = r_last;

    // The slot map and the chain must agree on how many timers are pending.
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_cell_valid) == $countones(r_busy))
        else $error("chain occupancy differs from slot map");

    // The head timer always belongs to a busy slot.
    a_head_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cells[0].valid |-> r_busy[w_cells[0].slot])
        else $error("head timer slot is not marked busy");

    // The first two cells stay in expiration order.
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cells[0].valid && w_cells[1].valid) |->
        (w_cells[0].expiry <= w_cells[1].expiry))
        else $error("chain head out of order");

    // A fired result is never the final one; a wait report always is.
    a_fired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_kind == tmq_pkg::KIND_FIRED) || (o_kind == tmq_pkg::KIND_WAIT))) |->
        (o_last == (o_kind == tmq_pkg::KIND_WAIT)))
        else $error("last flag wrong on execute result");

endmodule

`default_nettype wire

// ===== hdl/tmq_cell.sv =====
// One cell of the sorted timer chain: holds one timer and trades it with its neighbors.
`default_nettype none

module tmq_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tmq_pkg::t_cmd i_cmd,
    input  wire tmq_pkg::t_entry i_prev,
    input  wire logic          i_prev_gt,
    input  wire tmq_pkg::t_entry i_next,
    input  wire logic          i_found,
    output tmq_pkg::t_entry    o_entry,
    output logic               o_gt,
    output logic               o_found
);

    logic                                r_valid;
    logic [tmq_pkg::TIME_BITS-1:0]       r_expiry;
    logic [tmq_pkg::TAG_BITS-1:0]        r_tag;
    logic [tmq_pkg::SLOT_BITS-1:0]       r_slot;
    tmq_pkg::t_entry                     n_entry;
    logic                                w_match;

    always_comb begin
        o_entry.valid  = r_valid;
        o_entry.expiry = r_expiry;
        o_entry.tag    = r_tag;
        o_entry.slot   = r_slot;
        // An empty cell counts as later than any new timer, so an insert can fill it.
        o_gt    = !r_valid || (r_expiry > i_cmd.entry.expiry);
        w_match = r_valid && (r_slot == i_cmd.rm_slot);
        o_found = i_found || w_match;
    end

    always_comb begin
        n_entry = o_entry;
        case (i_cmd.op)
            tmq_pkg::OP_INSERT: begin
                if (o_gt) begin
                    n_entry = i_prev_gt ? i_prev : i_cmd.entry;
                end
            end
            tmq_pkg::OP_REMOVE: begin
                if (o_found) begin
                    n_entry = i_next;
                end
            end
            tmq_pkg::OP_POP: begin
                n_entry = i_next;
            end
            default: begin
                n_entry = o_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_expiry <= n_entry.expiry;
        r_tag    <= n_entry.tag;
        r_slot   <= n_entry.slot;
    end

endmodule

`default_nettype wire

// ===== hdl/tmq_chain.sv =====
// Row of timer cells kept sorted by expiration, earliest at the head.
`default_nettype none

module tmq_chain (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tmq_pkg::t_cmd i_cmd,
    output tmq_pkg::t_entry    o_cells [tmq_pkg::TIMER_SLOTS]
);

    tmq_pkg::t_entry w_entry [tmq_pkg::TIMER_SLOTS];
    logic            w_gt    [tmq_pkg::TIMER_SLOTS];
    logic            w_found [tmq_pkg::TIMER_SLOTS];

    for (genvar g = 0; g < tmq_pkg::TIMER_SLOTS; g++) begin : g_cell
        tmq_pkg::t_entry w_prev;
        tmq_pkg::t_entry w_next;
        logic            w_prev_gt;
        logic            w_found_in;

        if (g == 0) begin : g_head
            assign w_prev     = tmq_pkg::EMPTY_ENTRY;
            assign w_prev_gt  = 1'b0;
            assign w_found_in = 1'b0;
        end else begin : g_body
            assign w_prev     = w_entry[g-1];
            assign w_prev_gt  = w_gt[g-1];
            assign w_found_in = w_found[g-1];
        end

        if (g == tmq_pkg::TIMER_SLOTS - 1) begin : g_tail
            assign w_next = tmq_pkg::EMPTY_ENTRY;
        end else begin : g_inner
            assign w_next = w_entry[g+1];
        end

        tmq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (i_cmd),
            .i_prev    (w_prev),
            .i_prev_gt (w_prev_gt),
            .i_next    (w_next),
            .i_found   (w_found_in),
            .o_entry   (w_entry[g]),
            .o_gt      (w_gt[g]),
            .o_found   (w_found[g])
        );

        assign o_cells[g] = w_entry[g];
    end

endmodule

`default_nettype wire

// ===== tb/tb_timer_expiry_queue.sv =====
// Self-checking testbench of the timer expiry queue, with its own timer-table predictor.
module tb_timer_expiry_queue;
    timeunit 1ns;
    timeprecision 1ps;

    // The queue is driven with a short table of directed items and then with
    // several phases of random items. Each accepted transfer into the block is run
    // through a predictor of the timer table kept here, and the reports it
    // produces are queued. Each report transfer out of the block is compared, field
    // by field, with the oldest queued report. Sender gaps and receiver stalls are
    // switched per phase so that they fall on every step of the block's work.

    localparam int TMB = tmq_pkg::TIME_BITS;
    localparam int TOB = tmq_pkg::TIMEOUT_BITS;
    localparam int TGB = tmq_pkg::TAG_BITS;
    localparam int SLB = tmq_pkg::SLOT_BITS;
    localparam int NSL = tmq_pkg::TIMER_SLOTS;

    localparam logic [TMB-1:0] NOW_TOP         = '1;
    localparam logic [TOB-1:0] TIMEOUT_TOP     = '1;
    localparam logic [1:0]     FUNC_UNUSED     = 2'd3;
    localparam int             DIRECTED_ROWS   = 25;
    localparam int             ITEMS_PER_PHASE = 44;
    localparam int             DRAIN_CYCLES    = 40;

    // One report as the block presents it on its output side.
    typedef struct packed {
        logic [1:0]     kind;
        logic [1:0]     status;
        logic [SLB-1:0] slot;
        logic [TGB-1:0] tag;
        logic [TMB-1:0] wait_ms;
        logic           last;
    } t_report;

    // One input item. Rows with fixed set carry their single report typed in.
    typedef struct packed {
        logic [1:0]     func;
        logic [TMB-1:0] now;
        logic [TOB-1:0] timeout;
        logic [TGB-1:0] tag;
        logic [SLB-1:0] handle;
        bit             fixed;
        logic [1:0]     kind;
        logic [1:0]     status;
        logic [SLB-1:0] slot;
        logic [TMB-1:0] wait_ms;
    } t_stim_row;

    logic           i_clk        = 1'b0;
    logic           i_rst_n      = 1'b0;
    logic           i_valid      = 1'b0;
    logic           o_ready;
    logic [1:0]     i_func       = tmq_pkg::FUNC_ADD;
    logic [TMB-1:0] i_now_ms     = '0;
    logic [TOB-1:0] i_timeout_ms = '0;
    logic [TGB-1:0] i_owner_tag  = '0;
    logic [SLB-1:0] i_handle     = '0;
    logic           o_valid;
    logic           i_ready      = 1'b0;
    logic [1:0]     o_kind;
    logic [1:0]     o_status;
    logic [SLB-1:0] o_slot;
    logic [TGB-1:0] o_tag_out;
    logic [TMB-1:0] o_wait_ms;
    logic           o_last;

    timer_expiry_queue DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_now_ms     (i_now_ms),
        .i_timeout_ms (i_timeout_ms),
        .i_owner_tag  (i_owner_tag),
        .i_handle     (i_handle),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_tag_out    (o_tag_out),
        .o_wait_ms    (o_wait_ms),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Predicted timer table: which slots hold a timer, when each expires, its
    // owner tag and the value of the insertion counter when it was added.
    logic           tm_live   [NSL];
    logic [TMB-1:0] tm_expiry [NSL];
    logic [TGB-1:0] tm_tag    [NSL];
    logic [31:0]    tm_seq    [NSL];
    logic [31:0]    seq_count;

    t_report        awaited_reports[$];
    int             fail_count     = 0;
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    logic [TMB-1:0] wall_ms;
    t_stim_row      dir_tab [DIRECTED_ROWS];

    function automatic void owe(input bit emit, input logic [1:0] kind,
                                input logic [1:0] status, input logic [SLB-1:0] slot,
                                input logic [TGB-1:0] tag,
                                input logic [TMB-1:0] wait_ms, input logic last);
        t_report r;
        r = '{kind: kind, status: status, slot: slot, tag: tag, wait_ms: wait_ms, last: last};
        if (emit) begin
            awaited_reports.push_back(r);
        end
    endfunction

    // The timer that fires next: earliest expiration, and among equal expirations
    // the one added longest ago. Age is taken modulo 2^32 so that a wrap of the
    // insertion counter does not reorder timers.
    function automatic int soonest_slot();
        int          best;
        logic [31:0] age_i;
        logic [31:0] age_b;
        best = -1;
        for (int i = 0; i < NSL; i++) begin
            if (tm_live[i]) begin
                if (best < 0 || tm_expiry[i] < tm_expiry[best]) begin
                    best = i;
                end else if (tm_expiry[i] == tm_expiry[best]) begin
                    age_i = seq_count - tm_seq[i];
                    age_b = seq_count - tm_seq[best];
                    if (age_i > age_b) begin
                        best = i;
                    end
                end
            end
        end
        return best;
    endfunction

    // Applies one accepted item to the predicted table and, when emit is set,
    // queues the reports it causes.
    function automatic void model_timer_op(input logic [1:0] func,
                                           input logic [TMB-1:0] now,
                                           input logic [TOB-1:0] timeout,
                                           input logic [TGB-1:0] tag,
                                           input logic [SLB-1:0] handle,
                                           input bit emit);
        logic [TMB:0]   sum;
        logic [TMB-1:0] wait_left;
        int             free_slot;
        int             head;
        int             fired;
        bit             done;
        free_slot = -1;
        wait_left = '0;
        fired     = 0;
        done      = 1'b0;
        case (func)
            tmq_pkg::FUNC_ADD: begin
                for (int i = NSL - 1; i >= 0; i--) begin
                    if (!tm_live[i]) begin
                        free_slot = i;
                    end
                end
                if (free_slot < 0) begin
                    owe(emit, tmq_pkg::KIND_ADD_ACK, tmq_pkg::STATUS_FULL, '0, '0, '0, 1'b1);
                end else begin
                    // Expiration saturates at the largest time value.
                    sum = {1'b0, now} + {{(TMB + 1 - TOB){1'b0}}, timeout};
                    tm_live[free_slot]   = 1'b1;
                    tm_expiry[free_slot] = sum[TMB] ? NOW_TOP : sum[TMB-1:0];
                    tm_tag[free_slot]    = tag;
                    tm_seq[free_slot]    = seq_count;
                    seq_count            = seq_count + 32'd1;
                    owe(emit, tmq_pkg::KIND_ADD_ACK, tmq_pkg::STATUS_OK, SLB'(free_slot),
                        '0, '0, 1'b1);
                end
            end
            tmq_pkg::FUNC_REMOVE: begin
                if (tm_live[handle]) begin
                    tm_live[handle] = 1'b0;
                    owe(emit, tmq_pkg::KIND_REMOVE_ACK, tmq_pkg::STATUS_OK, handle,
                        '0, '0, 1'b1);
                end else begin
                    owe(emit, tmq_pkg::KIND_REMOVE_ACK, tmq_pkg::STATUS_NOT_ACTIVE, handle,
                        '0, '0, 1'b1);
                end
            end
            tmq_pkg::FUNC_EXEC: begin
                while (!done) begin
                    head = soonest_slot();
                    if (head < 0) begin
                        wait_left = '0;
                        done      = 1'b1;
                    end else if (tm_expiry[head] > now) begin
                        wait_left = tm_expiry[head] - now;
                        done      = 1'b1;
                    end else if (fired >= tmq_pkg::MAX_FIRES) begin
                        // Due timers left over fire on the next execute.
                        wait_left = '0;
                        done      = 1'b1;
                    end else begin
                        owe(emit, tmq_pkg::KIND_FIRED, tmq_pkg::STATUS_OK, SLB'(head),
                            tm_tag[head], '0, 1'b0);
                        tm_live[head] = 1'b0;
                        fired++;
                    end
                end
                owe(emit, tmq_pkg::KIND_WAIT, tmq_pkg::STATUS_OK, '0, '0, wait_left, 1'b1);
            end
            default: begin
                // The unused operation code is ignored by the block.
            end
        endcase
    endfunction

    function automatic t_stim_row mk_row(input logic [1:0] func,
                                         input logic [TMB-1:0] now,
                                         input logic [TOB-1:0] timeout,
                                         input logic [TGB-1:0] tag,
                                         input logic [SLB-1:0] handle,
                                         input bit fixed, input logic [1:0] kind,
                                         input logic [1:0] status,
                                         input logic [SLB-1:0] slot,
                                         input logic [TMB-1:0] wait_ms);
        t_stim_row r;
        r = '{func: func, now: now, timeout: timeout, tag: tag, handle: handle,
              fixed: fixed, kind: kind, status: status, slot: slot, wait_ms: wait_ms};
        return r;
    endfunction

    function automatic logic [TMB-1:0] random_time();
        return {16'($urandom_range(16'hFFFF)), 32'($urandom)};
    endfunction

    // Random items are mostly well-formed traffic around a wall clock that moves
    // forward, so that timers really come due; now and then the clock jumps to
    // an arbitrary value, and a few items use the unused operation code.
    function automatic t_stim_row random_row();
        t_stim_row r;
        int        pick;
        int        tsel;
        r        = '0;
        r.tag    = 16'($urandom);
        r.handle = SLB'($urandom);
        r.now    = random_time();
        r.timeout = TOB'($urandom);
        pick     = $urandom_range(99);
        if (pick < 5) begin
            r.func = FUNC_UNUSED;
        end else if (pick < 45) begin
            r.func = tmq_pkg::FUNC_ADD;
            if ($urandom_range(9) != 0) begin
                r.now = wall_ms;
            end
            tsel = $urandom_range(9);
            if (tsel < 6) begin
                r.timeout = TOB'($urandom_range(200));
            end else if (tsel == 9) begin
                r.timeout = TIMEOUT_TOP;
            end
        end else if (pick < 62) begin
            r.func = tmq_pkg::FUNC_REMOVE;
        end else begin
            r.func = tmq_pkg::FUNC_EXEC;
            if ($urandom_range(24) == 0) begin
                wall_ms = random_time();
            end else begin
                wall_ms = wall_ms + TMB'($urandom_range(90));
            end
            r.now = wall_ms;
        end
        return r;
    endfunction

    // Offers one item and returns at the clock edge of its transfer. Valid is
    // lowered only when a gap is taken, so back-to-back items keep it high.
    task automatic offer_item(input t_stim_row r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= r.func;
        i_now_ms     <= r.now;
        i_timeout_ms <= r.timeout;
        i_owner_tag  <= r.tag;
        i_handle     <= r.handle;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        // Typed-in rows still update the predicted table but queue their own report.
        model_timer_op(r.func, r.now, r.timeout, r.tag, r.handle, !r.fixed);
        owe(r.fixed, r.kind, r.status, r.slot, '0, r.wait_ms, 1'b1);
    endtask

    function automatic void cmp_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Output side: every report transfer is checked against the oldest queued
    // report, and the receiver's ready is redrawn each cycle from the stall rate.
    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (awaited_reports.size() == 0) begin
                $error("report transfer with nothing awaited: kind %0h slot %0h",
                       o_kind, o_slot);
                fail_count++;
            end else begin
                want = awaited_reports.pop_front();
                cmp_field("kind",    64'(want.kind),    64'(o_kind));
                cmp_field("status",  64'(want.status),  64'(o_status));
                cmp_field("slot",    64'(want.slot),    64'(o_slot));
                cmp_field("tag_out", 64'(want.tag),     64'(o_tag_out));
                cmp_field("wait_ms", 64'(want.wait_ms), 64'(o_wait_ms));
                cmp_field("last",    64'(want.last),    64'(o_last));
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        int useful;
        for (int i = 0; i < NSL; i++) begin
            tm_live[i]   = 1'b0;
            tm_expiry[i] = '0;
            tm_tag[i]    = '0;
            tm_seq[i]    = '0;
        end
        seq_count = '0;
        wall_ms   = TMB'($urandom_range(1000));

        // Directed table. The fixed rows are those whose report is plain: an
        // execute on an empty table, removes of inactive and active handles, the first
        // adds after reset (one of them saturating) and an add into a full table.
        dir_tab[0] = mk_row(tmq_pkg::FUNC_EXEC, '0, '0, '0, '0,
                            1'b1, tmq_pkg::KIND_WAIT, tmq_pkg::STATUS_OK, '0, '0);
        dir_tab[1] = mk_row(tmq_pkg::FUNC_REMOVE, '0, '0, '0, 4'hF,
                            1'b1, tmq_pkg::KIND_REMOVE_ACK, tmq_pkg::STATUS_NOT_ACTIVE,
                            4'hF, '0);
        dir_tab[2] = mk_row(tmq_pkg::FUNC_ADD, '0, '0, 16'hFFFF, '0,
                            1'b1, tmq_pkg::KIND_ADD_ACK, tmq_pkg::STATUS_OK, 4'd0, '0);
        dir_tab[3] = mk_row(tmq_pkg::FUNC_ADD, NOW_TOP, TIMEOUT_TOP, '0, '0,
                            1'b1, tmq_pkg::KIND_ADD_ACK, tmq_pkg::STATUS_OK, 4'd1, '0);
        dir_tab[4] = mk_row(tmq_pkg::FUNC_ADD, NOW_TOP - 48'd9, 31'd5, 16'hA5A5, '0,
                            1'b1, tmq_pkg::KIND_ADD_ACK, tmq_pkg::STATUS_OK, 4'd2, '0);
        dir_tab[5] = mk_row(tmq_pkg::FUNC_EXEC, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0);
        dir_tab[6] = mk_row(tmq_pkg::FUNC_REMOVE, '0, '0, '0, 4'd0,
                            1'b1, tmq_pkg::KIND_REMOVE_ACK, tmq_pkg::STATUS_NOT_ACTIVE,
                            4'd0, '0);
        dir_tab[7] = mk_row(tmq_pkg::FUNC_REMOVE, '0, '0, '0, 4'd1,
                            1'b1, tmq_pkg::KIND_REMOVE_ACK, tmq_pkg::STATUS_OK, 4'd1, '0);
        // Fill the table with fifteen timers of one shared expiration so that the final
        // execute must fire all sixteen, the equal ones in the order added.
        for (int k = 0; k < 15; k++) begin
            dir_tab[8 + k] = mk_row(tmq_pkg::FUNC_ADD, 48'h8000_0000_0000, 31'h4000_0000,
                                    16'h1000 + 16'(k), '0, 1'b0, '0, '0, '0, '0);
        end
        dir_tab[23] = mk_row(tmq_pkg::FUNC_ADD, 48'h1234, 31'd7, 16'h5555, '0,
                             1'b1, tmq_pkg::KIND_ADD_ACK, tmq_pkg::STATUS_FULL, 4'd0, '0);
        dir_tab[24] = mk_row(tmq_pkg::FUNC_EXEC, NOW_TOP, '0, '0, '0,
                             1'b0, '0, '0, '0, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            offer_item(dir_tab[r]);
        end

        // Random phases: no idling, sender gaps, receiver stalls, then both lightly.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            useful = 0;
            while (useful < ITEMS_PER_PHASE) begin
                t_stim_row r;
                r = random_row();
                offer_item(r);
                if (r.func != FUNC_UNUSED) begin
                    useful++;
                end
            end
        end

        i_valid <= 1'b0;
        recv_stall_pct = 0;
        while (awaited_reports.size() != 0) begin
            @(posedge i_clk);
        end
        // Let any stray report show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
